### rtl/core/mcl_pkg.sv
// shared types, widths and constant-divisor remainder functions for the channel argmax block
package mcl_pkg;

    localparam int LEVEL_W      = 8;
    localparam int COORD_W      = 16;
    localparam int POS_W        = COORD_W + 1;
    localparam int LABEL_W      = 4;
    localparam int CH_CNT_W     = 4;
    localparam int MAX_CHANNELS = 8;
    localparam int REM_W        = 3;

    localparam logic [CH_CNT_W-1:0] CH_CNT_RESET = CH_CNT_W'(8);

    // load strobes of the four pipeline stages
    typedef struct packed {
        logic a;
        logic b;
        logic c;
        logic d;
    } stage_en_t;

    typedef logic [REM_W-1:0] rem_arr_t [MAX_CHANNELS];

    // remainder by 3: fold 2-bit digits since 4 = 1 mod 3
    function automatic logic [REM_W-1:0] mod3(input logic [POS_W-1:0] x);
        logic [4:0] s1;
        logic [2:0] s2;
        s1 = 5'(x[16]);
        for (int i = 0; i < 8; i++)
        begin
            s1 = s1 + 5'(x[2*i +: 2]);
        end
        s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
        if (s2 >= 3'd3)
        begin
            s2 = s2 - 3'd3;
        end
        if (s2 >= 3'd3)
        begin
            s2 = s2 - 3'd3;
        end
        return s2;
    endfunction

    // remainder by 5: fold 4-bit digits since 16 = 1 mod 5
    function automatic logic [REM_W-1:0] mod5(input logic [POS_W-1:0] x);
        logic [5:0] s1;
        logic [4:0] s2;
        s1 = 6'(x[16]);
        for (int i = 0; i < 4; i++)
        begin
            s1 = s1 + 6'(x[4*i +: 4]);
        end
        s2 = 5'(s1[3:0]) + 5'(s1[5:4]);
        for (int j = 0; j < 3; j++)
        begin
            if (s2 >= 5'd5)
            begin
                s2 = s2 - 5'd5;
            end
        end
        return s2[REM_W-1:0];
    endfunction

    // remainder by 7: fold 3-bit digits since 8 = 1 mod 7
    function automatic logic [REM_W-1:0] mod7(input logic [POS_W-1:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        s1 = 6'(x[16:15]);
        for (int i = 0; i < 5; i++)
        begin
            s1 = s1 + 6'(x[3*i +: 3]);
        end
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        if (s2 >= 4'd7)
        begin
            s2 = s2 - 4'd7;
        end
        return s2[REM_W-1:0];
    endfunction

    // remainder by 6 from the remainder by 3 and the parity
    function automatic logic [REM_W-1:0] mod6(input logic [POS_W-1:0] x);
        logic [REM_W-1:0] r3;
        r3 = mod3(x);
        if (r3[0] == x[0])
        begin
            return r3;
        end
        return r3 + 3'd3;
    endfunction

endpackage

### rtl/core/mcl_in_if.sv
// pixel request channel: eight channel levels plus the pixel coordinates
interface mcl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] level_0;
    logic [7:0] level_1;
    logic [7:0] level_2;
    logic [7:0] level_3;
    logic [7:0] level_4;
    logic [7:0] level_5;
    logic [7:0] level_6;
    logic [7:0] level_7;
    logic [15:0] column;
    logic [15:0] row;

    modport source (
        output valid, level_0, level_1, level_2, level_3,
               level_4, level_5, level_6, level_7, column, row,
        input  ready
    );

    modport sink (
        input  valid, level_0, level_1, level_2, level_3,
               level_4, level_5, level_6, level_7, column, row,
        output ready
    );
endinterface

### rtl/core/mcl_out_if.sv
// label request channel carrying the winning channel number
interface mcl_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] label;

    modport source (
        output valid, label,
        input  ready
    );

    modport sink (
        input  valid, label,
        output ready
    );
endinterface

### rtl/core/max_channel_label_top.sv
// top level of the per-pixel channel argmax labeler
//
// Each pixel request on pix carries one byte per channel plus the pixel's
// column and row; res returns one label per pixel, in order. The label is
// the 1-based number of the channel with the largest value among the first
// channels_used channels (0 or above NUM_CHANNELS is clamped to 1 or
// NUM_CHANNELS). Ties are broken by (column + row) modulo the tie count,
// indexing the tied channels in ascending order; an all-zero pixel gives 0.
// cfg_we/cfg_wdata write channels_used; write it only while no pixel is
// in flight.
// An accepted pixel passes the four register stages (capture, lane max, tie
// detect, pick) in that order before its label appears on res. One pixel is
// accepted per cycle while pix.ready is high. When res stalls, stages keep
// filling until every bubble is taken, then pix.ready drops.
// Reset empties the pipeline and sets channels_used to 8.
module max_channel_label_top #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mcl_pkg::CH_CNT_W-1:0]   cfg_wdata,
    mcl_in_if.sink                         pix,
    mcl_out_if.source                      res
);

    logic [mcl_pkg::CH_CNT_W-1:0] ch_cnt_reg;
    logic [mcl_pkg::CH_CNT_W-1:0] ch_eff;
    logic                         va_reg;
    logic                         vb_reg;
    logic                         vc_reg;
    logic                         vd_reg;
    mcl_pkg::stage_en_t           en;
    logic [mcl_pkg::POS_W-1:0]    pos_a_reg;
    logic [mcl_pkg::POS_W-1:0]    pos_a_next;
    logic [mcl_pkg::LEVEL_W-1:0]  level_arr [mcl_pkg::MAX_CHANNELS];
    logic [mcl_pkg::LEVEL_W-1:0]  value_a [NUM_CHANNELS];
    logic [mcl_pkg::LEVEL_W-1:0]  best;
    logic [NUM_CHANNELS-1:0]      tie_c;

    // channel count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_cnt_reg <= mcl_pkg::CH_CNT_RESET;
        end
        else if (cfg_we)
        begin
            ch_cnt_reg <= cfg_wdata;
        end
    end

    // clamp the count into 1..NUM_CHANNELS
    always_comb
    begin
        ch_eff = ch_cnt_reg;
        if (ch_eff == '0)
        begin
            ch_eff = mcl_pkg::CH_CNT_W'(1);
        end
        if (ch_eff > mcl_pkg::CH_CNT_W'(NUM_CHANNELS))
        begin
            ch_eff = mcl_pkg::CH_CNT_W'(NUM_CHANNELS);
        end
    end

    // stage loads: a stage moves when it is empty or its successor moves
    assign en.d = !vd_reg || res.ready;
    assign en.c = !vc_reg || en.d;
    assign en.b = !vb_reg || en.c;
    assign en.a = !va_reg || en.b;
    assign pix.ready = en.a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            if (en.a)
            begin
                va_reg <= pix.valid;
            end
            if (en.b)
            begin
                vb_reg <= va_reg;
            end
            if (en.c)
            begin
                vc_reg <= vb_reg;
            end
            if (en.d)
            begin
                vd_reg <= vc_reg;
            end
        end
    end

    // tie-break position
    assign pos_a_next = mcl_pkg::POS_W'(pix.column) + mcl_pkg::POS_W'(pix.row);

    always_ff @(posedge clk)
    begin
        if (en.a)
        begin
            pos_a_reg <= pos_a_next;
        end
    end

    assign level_arr[0] = pix.level_0;
    assign level_arr[1] = pix.level_1;
    assign level_arr[2] = pix.level_2;
    assign level_arr[3] = pix.level_3;
    assign level_arr[4] = pix.level_4;
    assign level_arr[5] = pix.level_5;
    assign level_arr[6] = pix.level_6;
    assign level_arr[7] = pix.level_7;

    // one lane per channel
    for (genvar g = 0; g < NUM_CHANNELS; g++)
    begin : g_lane
        mcl_lane u_lane (
            .clk     (clk),
            .en      (en),
            .level   (level_arr[g]),
            .active  (mcl_pkg::CH_CNT_W'(g) < ch_eff),
            .best    (best),
            .value_a (value_a[g]),
            .tie_c   (tie_c[g])
        );
    end

    mcl_max #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_max (
        .clk   (clk),
        .en    (en),
        .value (value_a),
        .best  (best)
    );

    mcl_pick #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_pick (
        .clk   (clk),
        .en    (en),
        .pos_a (pos_a_reg),
        .tie_c (tie_c),
        .label (res.label)
    );

    assign res.valid = vd_reg;

endmodule

### rtl/core/mcl_lane.sv
// one channel lane: gated level capture and tie detection against the maximum
module mcl_lane (
    input  logic                         clk,
    input  mcl_pkg::stage_en_t           en,
    input  logic [mcl_pkg::LEVEL_W-1:0]  level,
    input  logic                         active,
    input  logic [mcl_pkg::LEVEL_W-1:0]  best,
    output logic [mcl_pkg::LEVEL_W-1:0]  value_a,
    output logic                         tie_c
);

    logic [mcl_pkg::LEVEL_W-1:0] value_a_reg;
    logic [mcl_pkg::LEVEL_W-1:0] value_a_next;
    logic [mcl_pkg::LEVEL_W-1:0] value_b_reg;
    logic                        tie_c_reg;
    logic                        tie_c_next;

    // channels outside the configured count read as zero
    assign value_a_next = active ? level : '0;

    // a lane ties when it holds a nonzero maximum
    assign tie_c_next = (value_b_reg == best) && (best != '0);

    always_ff @(posedge clk)
    begin
        if (en.a)
        begin
            value_a_reg <= value_a_next;
        end
        if (en.b)
        begin
            value_b_reg <= value_a_reg;
        end
        if (en.c)
        begin
            tie_c_reg <= tie_c_next;
        end
    end

    assign value_a = value_a_reg;
    assign tie_c   = tie_c_reg;

endmodule

### rtl/core/mcl_max.sv
// merge stage: maximum over all lane values
module mcl_max #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                         clk,
    input  mcl_pkg::stage_en_t           en,
    input  logic [mcl_pkg::LEVEL_W-1:0]  value [NUM_CHANNELS],
    output logic [mcl_pkg::LEVEL_W-1:0]  best
);

    logic [mcl_pkg::LEVEL_W-1:0] best_reg;
    logic [mcl_pkg::LEVEL_W-1:0] best_next;

    // running compare across the lanes
    always_comb
    begin
        best_next = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (value[i] > best_next)
            begin
                best_next = value[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.b)
        begin
            best_reg <= best_next;
        end
    end

    assign best = best_reg;

endmodule

### rtl/core/mcl_pick.sv
// merge stage: tie-break remainders and selection of the winning lane
module mcl_pick #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                         clk,
    input  mcl_pkg::stage_en_t           en,
    input  logic [mcl_pkg::POS_W-1:0]    pos_a,
    input  logic [NUM_CHANNELS-1:0]      tie_c,
    output logic [mcl_pkg::LABEL_W-1:0]  label
);

    mcl_pkg::rem_arr_t            rem_b_reg;
    mcl_pkg::rem_arr_t            rem_b_next;
    mcl_pkg::rem_arr_t            rem_c_reg;
    logic [mcl_pkg::LABEL_W-1:0]  label_reg;
    logic [mcl_pkg::LABEL_W-1:0]  label_next;
    logic [mcl_pkg::CH_CNT_W-1:0] tie_cnt;
    logic [mcl_pkg::CH_CNT_W-1:0] run_cnt;
    logic [mcl_pkg::REM_W-1:0]    pick_idx;

    // position modulo every possible tie count, entry t-1 for count t
    always_comb
    begin
        rem_b_next[0] = '0;
        rem_b_next[1] = 3'(pos_a[0]);
        rem_b_next[2] = mcl_pkg::mod3(pos_a);
        rem_b_next[3] = 3'(pos_a[1:0]);
        rem_b_next[4] = mcl_pkg::mod5(pos_a);
        rem_b_next[5] = mcl_pkg::mod6(pos_a);
        rem_b_next[6] = mcl_pkg::mod7(pos_a);
        rem_b_next[7] = pos_a[2:0];
    end

    // count the ties, then take the tied lane whose rank matches the remainder
    always_comb
    begin
        tie_cnt = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            tie_cnt = tie_cnt + mcl_pkg::CH_CNT_W'(tie_c[i]);
        end
        pick_idx = rem_c_reg[mcl_pkg::REM_W'(tie_cnt - 4'd1)];
        run_cnt = '0;
        label_next = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (tie_c[i] && (run_cnt == mcl_pkg::CH_CNT_W'(pick_idx)))
            begin
                label_next = mcl_pkg::LABEL_W'(i + 1);
            end
            run_cnt = run_cnt + mcl_pkg::CH_CNT_W'(tie_c[i]);
        end
        if (tie_cnt == '0)
        begin
            label_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.b)
        begin
            rem_b_reg <= rem_b_next;
        end
        if (en.c)
        begin
            rem_c_reg <= rem_b_reg;
        end
        if (en.d)
        begin
            label_reg <= label_next;
        end
    end

    assign label = label_reg;

endmodule
